/* rtl/morse_element_sequencer_macros.svh */
// Assertion macros for the Morse element sequencer checker.
`ifndef MORSE_ELEMENT_SEQUENCER_MACROS_SVH
`define MORSE_ELEMENT_SEQUENCER_MACROS_SVH

// Check a same-cycle implication, quiet while reset is asserted.
`define MES_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle, quiet while reset is asserted.
`define MES_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mes_pkg.sv */
// Package for the Morse element sequencer: codes, defaults and the character table.
`default_nettype none

package mes_pkg;

    localparam int unsigned MAX_PITCHES_DEF  = 256;
    localparam int unsigned MAX_ELEMENTS_DEF = 6;

    localparam int unsigned CODE_W     = 6;
    localparam int unsigned CODE_LEN_W = 3;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [15:0] DOT_TIME_RST     = 16'd200;
    localparam logic [15:0] DASH_TIME_RST    = 16'd400;
    localparam logic [15:0] LETTER_GAP_RST   = 16'd300;
    localparam logic [15:0] WORD_GAP_RST     = 16'd700;
    localparam logic [8:0]  PITCH_COUNT_RST  = 9'd12;
    localparam logic        PITCH_RANDOM_RST = 1'b1;
    localparam logic [15:0] LFSR_SEED        = 16'hACE1;

    typedef enum logic [2:0] {
        KIND_DOT         = 3'd0,
        KIND_DASH        = 3'd1,
        KIND_LETTER_REST = 3'd2,
        KIND_WORD_REST   = 3'd3,
        KIND_TOTAL       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_DOT_TIME     = 3'd0,
        REG_DASH_TIME    = 3'd1,
        REG_LETTER_GAP   = 3'd2,
        REG_WORD_GAP     = 3'd3,
        REG_PITCH_COUNT  = 3'd4,
        REG_PITCH_RANDOM = 3'd5
    } reg_idx_t;

    // Element i (first = 0) is bit len-1-i; a one is a dash.
    typedef struct packed {
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_W-1:0]     bits;
    } code_t;

    localparam code_t LETTER_CODES [26] = '{
        '{3'd2, 6'd1},  '{3'd4, 6'd8},  '{3'd4, 6'd10}, '{3'd3, 6'd4},  '{3'd1, 6'd0},
        '{3'd4, 6'd2},  '{3'd3, 6'd6},  '{3'd4, 6'd0},  '{3'd2, 6'd0},  '{3'd4, 6'd7},
        '{3'd3, 6'd5},  '{3'd4, 6'd4},  '{3'd2, 6'd3},  '{3'd2, 6'd2},  '{3'd3, 6'd7},
        '{3'd4, 6'd6},  '{3'd4, 6'd13}, '{3'd3, 6'd2},  '{3'd3, 6'd0},  '{3'd1, 6'd1},
        '{3'd3, 6'd1},  '{3'd4, 6'd1},  '{3'd3, 6'd3},  '{3'd4, 6'd9},  '{3'd4, 6'd11},
        '{3'd4, 6'd12}
    };

    localparam code_t DIGIT_CODES [10] = '{
        '{3'd5, 6'd31}, '{3'd5, 6'd15}, '{3'd5, 6'd7},  '{3'd5, 6'd3},  '{3'd5, 6'd1},
        '{3'd5, 6'd0},  '{3'd5, 6'd16}, '{3'd5, 6'd24}, '{3'd5, 6'd28}, '{3'd5, 6'd30}
    };

    function automatic logic mes_is_space(input logic [7:0] c);
        return (c inside {[8'd9:8'd13], 8'd32});
    endfunction

    // Fold lower case and look the byte up; unknown bytes give length zero.
    function automatic code_t mes_lookup(input logic [7:0] c_in);
        logic [7:0] c;
        logic [7:0] ofs;
        code_t      code;
        c    = (c_in inside {[8'h61:8'h7A]}) ? (c_in - 8'd32) : c_in;
        code = '0;
        if (c inside {[8'h41:8'h5A]})
        begin
            ofs  = c - 8'h41;
            code = LETTER_CODES[ofs[4:0]];
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            ofs  = c - 8'h30;
            code = DIGIT_CODES[ofs[3:0]];
        end
        else
        begin
            ofs = '0;
            case (c)
                8'h2E:   code = '{3'd6, 6'd21};
                8'h2C:   code = '{3'd6, 6'd51};
                8'h3A:   code = '{3'd6, 6'd56};
                8'h3F:   code = '{3'd6, 6'd12};
                8'h27:   code = '{3'd6, 6'd30};
                8'h2D:   code = '{3'd6, 6'd33};
                8'h2F:   code = '{3'd5, 6'd18};
                8'h5B:   code = '{3'd6, 6'd45};
                8'h22:   code = '{3'd6, 6'd18};
                default: code = '0;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/morse_element_sequencer.sv */
// Morse element sequencer top level: decode, element sequencer, pitch unit and totaliser.
`default_nettype none

// A taken character first sets the sequencer state; its first request is then registered in
// the output register once that is free, and later requests follow one per cycle while the
// output side takes them. A new character is taken only once the sequencer is back in idle
// with all requests of the last one issued; a space at a word start leaves it idle.
// The rate is set by the single saturating adder and pitch unit, used once per element.
// Reset: registers return to their defaults, the sequence restarts at a word start, the
// pitch pointer and total clear and the LFSR loads its seed; no clearing pass is needed.
module morse_element_sequencer #(
    parameter int unsigned MAX_PITCHES  = mes_pkg::MAX_PITCHES_DEF,
    parameter int unsigned MAX_ELEMENTS = mes_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB-style configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mes_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // character requests
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic                       mode,
    input  logic [7:0]                 char_code,
    // element requests
    output logic                       elem_valid,
    input  logic                       elem_ready,
    output logic [2:0]                 kind,
    output logic [7:0]                 pitch_index,
    output logic [15:0]                duration,
    output logic [31:0]                total_time,
    output logic                       last
);

    import mes_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_ELEM_C = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] ONE_C      = CNT_W'(1);
    localparam logic [8:0]       MAX_PIT_C  = 9'(MAX_PITCHES);

    // One-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LETTER = 5'b00010,
        ST_TONE   = 5'b00100,
        ST_WORD   = 5'b01000,
        ST_TOTAL  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] dot_time_reg, dash_time_reg, letter_gap_reg, word_gap_reg;
    logic [8:0]  pitch_count_reg;
    logic        pitch_random_reg;

    // Sequence state
    logic        word_start_reg, word_start_next;
    logic [7:0]  cycle_ptr_reg, cycle_ptr_next;
    logic [15:0] lfsr_reg, lfsr_next;
    logic [31:0] total_reg, total_next;

    // Current character: left-justified element bits and elements still to go
    logic [CODE_W-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    // Output register
    logic        elem_valid_reg, elem_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  pitch_reg, pitch_next;
    logic [15:0] dur_reg, dur_next;
    logic [31:0] tot_reg, tot_next;
    logic        last_reg, last_next;

    logic        cfg_write;
    logic        accept;
    logic        out_free;
    logic        emit;
    code_t       code;
    logic [CNT_W-1:0]  len_eff;
    logic [CODE_W-1:0] bits_lj;

    // Shared saturating adder
    logic [15:0] add_operand;
    logic [32:0] sum_wide;
    logic [31:0] add_result;

    // Pitch unit
    logic        tone_dash;
    logic [15:0] tone_dur;
    logic [8:0]  n_eff;
    logic [8:0]  ptr_cur;
    logic [8:0]  ptr_inc;
    logic        fb_bit;
    logic [15:0] lfsr_step;
    logic [24:0] pitch_prod;
    logic [7:0]  tone_pitch;

    // ---------------------------------------------------------------------------
    // Configuration port: writes land on the access phase, reads are combinational
    // ---------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_DOT_TIME:     prdata = {16'd0, dot_time_reg};
            REG_DASH_TIME:    prdata = {16'd0, dash_time_reg};
            REG_LETTER_GAP:   prdata = {16'd0, letter_gap_reg};
            REG_WORD_GAP:     prdata = {16'd0, word_gap_reg};
            REG_PITCH_COUNT:  prdata = {23'd0, pitch_count_reg};
            REG_PITCH_RANDOM: prdata = {31'd0, pitch_random_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_time_reg     <= DOT_TIME_RST;
            dash_time_reg    <= DASH_TIME_RST;
            letter_gap_reg   <= LETTER_GAP_RST;
            word_gap_reg     <= WORD_GAP_RST;
            pitch_count_reg  <= PITCH_COUNT_RST;
            pitch_random_reg <= PITCH_RANDOM_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_DOT_TIME:     dot_time_reg     <= pwdata[15:0];
                REG_DASH_TIME:    dash_time_reg    <= pwdata[15:0];
                REG_LETTER_GAP:   letter_gap_reg   <= pwdata[15:0];
                REG_WORD_GAP:     word_gap_reg     <= pwdata[15:0];
                REG_PITCH_COUNT:  pitch_count_reg  <= pwdata[8:0];
                REG_PITCH_RANDOM: pitch_random_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------
    // Handshakes: take a character only when the sequencer is idle; the output
    // register is free once its request has gone or goes in this cycle
    // ---------------------------------------------------------------------------
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !elem_valid_reg || elem_ready;

    // Character decode; clamp the element count and left-justify the code bits
    assign code    = mes_lookup(char_code);
    assign len_eff = (CNT_W'(code.len) > MAX_ELEM_C) ? MAX_ELEM_C : CNT_W'(code.len);
    assign bits_lj = code.bits << (CODE_LEN_W'(CODE_W) - code.len);

    // Current tone: top bit of the shifted code picks dot or dash
    assign tone_dash = bits_reg[CODE_W-1];
    assign tone_dur  = tone_dash ? dash_time_reg : dot_time_reg;

    // ---------------------------------------------------------------------------
    // Pitch unit: clamp the count, drop a stale pointer, step the LFSR and scale it
    // ---------------------------------------------------------------------------
    assign n_eff = (pitch_count_reg == 9'd0)     ? 9'd1 :
                   (pitch_count_reg > MAX_PIT_C) ? MAX_PIT_C : pitch_count_reg;
    assign ptr_cur    = ({1'b0, cycle_ptr_reg} >= n_eff) ? 9'd0 : {1'b0, cycle_ptr_reg};
    assign ptr_inc    = ptr_cur + 9'd1;
    assign fb_bit     = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_step  = {fb_bit, lfsr_reg[15:1]};
    assign pitch_prod = {9'd0, lfsr_step} * {16'd0, n_eff};
    assign tone_pitch = pitch_random_reg ? pitch_prod[23:16] : ptr_cur[7:0];

    // ---------------------------------------------------------------------------
    // Shared saturating adder: one duration per emitted element
    // ---------------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            ST_LETTER: add_operand = letter_gap_reg;
            ST_WORD:   add_operand = word_gap_reg;
            ST_TONE:   add_operand = tone_dur;
            default:   add_operand = 16'd0;
        endcase
    end

    assign sum_wide   = {1'b0, total_reg} + {17'd0, add_operand};
    assign add_result = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

    // ---------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        word_start_next = word_start_reg;
        cycle_ptr_next  = cycle_ptr_reg;
        lfsr_next       = lfsr_reg;
        total_next      = total_reg;
        bits_next       = bits_reg;
        rem_next        = rem_reg;
        emit            = 1'b0;
        kind_next       = kind_reg;
        pitch_next      = pitch_reg;
        dur_next        = dur_reg;
        tot_next        = tot_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        word_start_next = 1'b1;
                        state_next      = ST_TOTAL;
                    end
                    else if (mes_is_space(char_code))
                    begin
                        // a space at a word start is swallowed
                        if (!word_start_reg)
                        begin
                            word_start_next = 1'b1;
                            state_next      = ST_WORD;
                        end
                    end
                    else
                    begin
                        // unknown bytes still count as a letter
                        word_start_next = 1'b0;
                        bits_next       = bits_lj;
                        rem_next        = len_eff;
                        if (!word_start_reg)
                            state_next = ST_LETTER;
                        else if (len_eff != '0)
                            state_next = ST_TONE;
                    end
                end
            end

            ST_TOTAL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_TOTAL;
                    pitch_next = 8'd0;
                    dur_next   = 16'd0;
                    tot_next   = total_reg;
                    last_next  = 1'b1;
                    total_next = 32'd0;
                    state_next = ST_IDLE;
                end
            end

            ST_WORD:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_WORD_REST;
                    pitch_next = 8'd0;
                    dur_next   = word_gap_reg;
                    tot_next   = 32'd0;
                    last_next  = 1'b1;
                    total_next = add_result;
                    state_next = ST_IDLE;
                end
            end

            ST_LETTER:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_LETTER_REST;
                    pitch_next = 8'd0;
                    dur_next   = letter_gap_reg;
                    tot_next   = 32'd0;
                    last_next  = (rem_reg == '0);
                    total_next = add_result;
                    state_next = (rem_reg == '0) ? ST_IDLE : ST_TONE;
                end
            end

            ST_TONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = tone_dash ? KIND_DASH : KIND_DOT;
                    pitch_next = tone_pitch;
                    dur_next   = tone_dur;
                    tot_next   = 32'd0;
                    last_next  = (rem_reg == ONE_C);
                    total_next = add_result;
                    // advance the pointer always, the LFSR only in random mode
                    cycle_ptr_next = (ptr_inc >= n_eff) ? 8'd0 : ptr_inc[7:0];
                    if (pitch_random_reg)
                        lfsr_next = lfsr_step;
                    bits_next  = bits_reg << 1;
                    rem_next   = rem_reg - ONE_C;
                    state_next = (rem_reg == ONE_C) ? ST_IDLE : ST_TONE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the request until taken, drop it once taken
        if (emit)
            elem_valid_next = 1'b1;
        else if (elem_ready)
            elem_valid_next = 1'b0;
        else
            elem_valid_next = elem_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_start_reg <= 1'b1;
            cycle_ptr_reg  <= 8'd0;
            lfsr_reg       <= LFSR_SEED;
            total_reg      <= 32'd0;
            elem_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_start_reg <= word_start_next;
            cycle_ptr_reg  <= cycle_ptr_next;
            lfsr_reg       <= lfsr_next;
            total_reg      <= total_next;
            elem_valid_reg <= elem_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        rem_reg   <= rem_next;
        kind_reg  <= kind_next;
        pitch_reg <= pitch_next;
        dur_reg   <= dur_next;
        tot_reg   <= tot_next;
        last_reg  <= last_next;
    end

    assign elem_valid  = elem_valid_reg;
    assign kind        = kind_reg;
    assign pitch_index = pitch_reg;
    assign duration    = dur_reg;
    assign total_time  = tot_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

/* rtl/mes_checker.sv */
// Port-level checker for the Morse element sequencer, bound to the top level.
`default_nettype none
`include "morse_element_sequencer_macros.svh"

module mes_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        elem_valid,
    input wire logic        elem_ready,
    input wire logic [2:0]  kind,
    input wire logic [7:0]  pitch_index,
    input wire logic [15:0] duration,
    input wire logic [31:0] total_time,
    input wire logic        last
);

    import mes_pkg::*;

    // a stalled element request holds
    `MES_ASSERT_NEXT(a_elem_hold, clk, rst_n, elem_valid && !elem_ready, elem_valid && $stable(kind) && $stable(duration) && $stable(total_time) && $stable(last), "element request changed while stalled")

    // a total closes its item and carries no pitch or duration
    `MES_ASSERT_NOW(a_total_shape, clk, rst_n, elem_valid && (kind == KIND_TOTAL), last && (pitch_index == 8'd0) && (duration == 16'd0), "malformed total request")

    // rests carry no pitch and no total
    `MES_ASSERT_NOW(a_rest_shape, clk, rst_n, elem_valid && ((kind == KIND_LETTER_REST) || (kind == KIND_WORD_REST)), (pitch_index == 8'd0) && (total_time == 32'd0), "malformed rest request")

    // a word rest is always the only result of its item
    `MES_ASSERT_NOW(a_word_last, clk, rst_n, elem_valid && (kind == KIND_WORD_REST), last, "word rest not marked last")

endmodule

bind morse_element_sequencer mes_checker u_mes_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .elem_valid  (elem_valid),
    .elem_ready  (elem_ready),
    .kind        (kind),
    .pitch_index (pitch_index),
    .duration    (duration),
    .total_time  (total_time),
    .last        (last)
);

`default_nettype wire
